// File: rtl/pulse_width_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// pulse width frame receiver assertion macros
// wraps concurrent assertions so that synthesis builds see empty bodies
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_FRAME_RECEIVER_DEFINES_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define PWFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pwfr assertion failed");
// same-cycle implication outside reset
`define PWFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwfr implication failed");
`else
`define PWFR_ASSERT(lbl, clk, rst_n, prop)
`define PWFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/pwfr_pkg.sv
// ----------------------------------------------------------------------------
// pwfr_pkg
// shared types, constants and helpers of the pulse width frame receiver
// ----------------------------------------------------------------------------
package pwfr_pkg;

    // ring buffer and symbol timing
    localparam int BUFFER_DEPTH   = 128;
    localparam int TICKS_PER_UNIT = 6;
    localparam int PTR_W          = $clog2(BUFFER_DEPTH);

    localparam int TICKS_W = 16;
    localparam int UNITS_W = 8;
    localparam int BYTE_W  = 8;
    localparam int BIT_W   = 4;
    localparam int BYTE_BITS = 8;

    // rounding divide: units = (2*ticks + TPU) / (2*TPU), exact reciprocal multiply
    localparam int UNIT_DIV    = 2 * TICKS_PER_UNIT;
    localparam int NUM_W       = $clog2(2 * (2 ** TICKS_W - 1) + UNIT_DIV + 1);
    localparam int RECIP_SHIFT = NUM_W + $clog2(UNIT_DIV);
    localparam int RECIP_W     = NUM_W + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + longint'(UNIT_DIV) - 64'd1) / longint'(UNIT_DIV);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    // configuration registers
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = $clog2(CFG_COUNT);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_HIGH = 4'd0,
        CFG_START_LOW  = 4'd1,
        CFG_ONE_HIGH   = 4'd2,
        CFG_ONE_LOW    = 4'd3,
        CFG_ZERO_HIGH  = 4'd4,
        CFG_ZERO_LOW   = 4'd5,
        CFG_END_HIGH   = 4'd6,
        CFG_END_LOW    = 4'd7
    } t_cfg_idx;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_READ = 2'd1,
        CMD_PAIR = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic start_hit;
        logic one_hit;
        logic zero_hit;
        logic end_hit;
    } t_match;

    typedef struct packed {
        t_cmd_kind kind;
        t_match    match;
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_START  = 3'd1,
        EV_BYTE   = 3'd2,
        EV_COMMIT = 3'd3,
        EV_DROP   = 3'd4,
        EV_ABORT  = 3'd5
    } t_event;

    function automatic t_ptr ring_next(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(BUFFER_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

    function automatic t_ptr ring_prev(input t_ptr p);
        t_ptr r;
        if (p == '0) begin
            r = t_ptr'(BUFFER_DEPTH - 1);
        end else begin
            r = p - t_ptr'(1);
        end
        return r;
    endfunction

endpackage

// File: rtl/pwfr_front.sv
// ----------------------------------------------------------------------------
// pwfr_front
// converts intervals to symbol units, pairs them and matches the code table
// ----------------------------------------------------------------------------
module pwfr_front import pwfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [UNITS_W-1:0]   i_cfg_data,
    output logic                 o_cfg_ready,
    input  logic                 i_valid,
    input  logic                 i_operation,
    input  logic [TICKS_W-1:0]   i_interval_ticks,
    input  logic                 i_interval_was_high,
    input  logic                 i_queue_ready,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [UNITS_W-1:0] r_cfg [CFG_COUNT];
    logic [UNITS_W-1:0] r_last_high;
    logic [NUM_W-1:0]   w_num;
    logic [PROD_W-1:0]  w_prod;
    logic [UNITS_W-1:0] w_units;
    logic               w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && i_queue_ready;
    assign o_push      = w_accept;

    // exact floor((2t + d) / 2d) via reciprocal, units kept modulo 256
    assign w_num   = NUM_W'({i_interval_ticks, 1'b0}) + NUM_W'(TICKS_PER_UNIT);
    assign w_prod  = PROD_W'(w_num) * PROD_W'(RECIP);
    assign w_units = w_prod[RECIP_SHIFT +: UNITS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                r_cfg[i] <= '0;
            end
            r_last_high <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(CFG_COUNT))) begin
                r_cfg[i_cfg_index[CFG_SEL_W-1:0]] <= i_cfg_data;
            end
            if (w_accept && !i_operation && i_interval_was_high) begin
                r_last_high <= w_units;
            end
        end
    end

    always_comb begin
        o_cmd.match.start_hit = (r_last_high == r_cfg[CFG_SEL_W'(CFG_START_HIGH)]) &&
                                (w_units == r_cfg[CFG_SEL_W'(CFG_START_LOW)]);
        o_cmd.match.one_hit   = (r_last_high == r_cfg[CFG_SEL_W'(CFG_ONE_HIGH)]) &&
                                (w_units == r_cfg[CFG_SEL_W'(CFG_ONE_LOW)]);
        o_cmd.match.zero_hit  = (r_last_high == r_cfg[CFG_SEL_W'(CFG_ZERO_HIGH)]) &&
                                (w_units == r_cfg[CFG_SEL_W'(CFG_ZERO_LOW)]);
        o_cmd.match.end_hit   = (r_last_high == r_cfg[CFG_SEL_W'(CFG_END_HIGH)]) &&
                                (w_units == r_cfg[CFG_SEL_W'(CFG_END_LOW)]);
        priority if (i_operation) begin
            o_cmd.kind = CMD_READ;
        end else if (i_interval_was_high) begin
            o_cmd.kind = CMD_NONE;
        end else begin
            o_cmd.kind = CMD_PAIR;
        end
    end

endmodule

// File: rtl/pwfr_queue.sv
// ----------------------------------------------------------------------------
// pwfr_queue
// small command fifo between the classifying front and the executing back
// ----------------------------------------------------------------------------
module pwfr_queue import pwfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              w_do_push;
    logic              w_do_pop;

    function automatic logic [QPTR_W-1:0] qnext(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + QPTR_W'(1);
        end
        return r;
    endfunction

    assign o_ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_slot[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        unique case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= qnext(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= qnext(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/pwfr_back.sv
// ----------------------------------------------------------------------------
// pwfr_back
// frame state, byte assembly, ring buffer and result register
// ----------------------------------------------------------------------------
`include "pulse_width_frame_receiver_defines.svh"

module pwfr_back import pwfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_read_data,
    output logic              o_read_valid,
    output t_event            o_event
);

    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];

    logic              r_listening;
    logic [BYTE_W-1:0] r_shift;
    logic [BIT_W-1:0]  r_bit_idx;
    t_ptr              r_wr_ptr;
    logic [BYTE_W-1:0] r_xor;
    t_ptr              r_commit_ptr;
    t_ptr              r_rd_ptr;

    logic              n_listening;
    logic [BYTE_W-1:0] n_shift;
    logic [BIT_W-1:0]  n_bit_idx;
    t_ptr              n_wr_ptr;
    logic [BYTE_W-1:0] n_xor;
    t_ptr              n_commit_ptr;
    t_ptr              n_rd_ptr;
    t_event            n_event;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_hit;
    t_event            r_out_event;

    logic              w_issue;
    logic              w_rd_hit;
    logic              w_store_en;
    logic              w_commit_move;
    logic [BYTE_W-1:0] w_shift_upd;
    logic [BIT_W-1:0]  w_bit_inc;

    assign w_issue   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop = w_issue;
    assign w_bit_inc = r_bit_idx + BIT_W'(1);

    always_comb begin
        w_shift_upd = r_shift;
        w_shift_upd[r_bit_idx[2:0]] = i_cmd.match.one_hit;
    end

    always_comb begin
        n_listening   = r_listening;
        n_shift       = r_shift;
        n_bit_idx     = r_bit_idx;
        n_wr_ptr      = r_wr_ptr;
        n_xor         = r_xor;
        n_commit_ptr  = r_commit_ptr;
        n_rd_ptr      = r_rd_ptr;
        n_event       = EV_NONE;
        w_rd_hit      = 1'b0;
        w_store_en    = 1'b0;
        w_commit_move = 1'b0;
        if (w_issue) begin
            unique case (i_cmd.kind)
                CMD_READ: begin
                    if (r_commit_ptr != r_rd_ptr) begin
                        w_rd_hit = 1'b1;
                        n_rd_ptr = ring_next(r_rd_ptr);
                    end
                end
                CMD_PAIR: begin
                    priority if (!r_listening) begin
                        // only the start code counts while idle
                        if (i_cmd.match.start_hit) begin
                            n_listening = 1'b1;
                            n_wr_ptr    = r_commit_ptr;
                            n_bit_idx   = '0;
                            n_shift     = '0;
                            n_xor       = '0;
                            n_event     = EV_START;
                        end
                    end else if (i_cmd.match.end_hit) begin
                        n_listening = 1'b0;
                        if (r_xor != '0) begin
                            n_event = EV_DROP;
                        end else begin
                            // drop the checksum byte, empty frame keeps the pointer
                            if (r_wr_ptr != r_commit_ptr) begin
                                n_commit_ptr  = ring_prev(r_wr_ptr);
                                w_commit_move = 1'b1;
                            end
                            n_event = EV_COMMIT;
                        end
                    end else if (i_cmd.match.one_hit || i_cmd.match.zero_hit) begin
                        n_shift   = w_shift_upd;
                        n_bit_idx = w_bit_inc;
                        if (w_bit_inc >= BIT_W'(BYTE_BITS)) begin
                            if (ring_next(r_wr_ptr) == r_rd_ptr) begin
                                n_listening = 1'b0;
                                n_event     = EV_ABORT;
                            end else begin
                                w_store_en = 1'b1;
                                n_xor      = r_xor ^ w_shift_upd;
                                n_bit_idx  = '0;
                                n_wr_ptr   = ring_next(r_wr_ptr);
                                n_event    = EV_BYTE;
                            end
                        end
                    end else begin
                        n_event = EV_NONE;
                    end
                end
                default: begin
                    n_event = EV_NONE;
                end
            endcase
        end
    end

    // ring buffer with registered read into the result register
    always_ff @(posedge i_clk) begin
        if (w_store_en) begin
            r_mem[r_wr_ptr] <= w_shift_upd;
        end
        if (w_issue) begin
            r_out_data  <= w_rd_hit ? r_mem[r_rd_ptr] : '0;
            r_out_hit   <= w_rd_hit;
            r_out_event <= n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listening  <= 1'b0;
            r_shift      <= '0;
            r_bit_idx    <= '0;
            r_wr_ptr     <= '0;
            r_xor        <= '0;
            r_commit_ptr <= '0;
            r_rd_ptr     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_listening  <= n_listening;
            r_shift      <= n_shift;
            r_bit_idx    <= n_bit_idx;
            r_wr_ptr     <= n_wr_ptr;
            r_xor        <= n_xor;
            r_commit_ptr <= n_commit_ptr;
            r_rd_ptr     <= n_rd_ptr;
            if (w_issue) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_out_data;
    assign o_read_valid = r_out_hit;
    assign o_event      = r_out_event;

    `PWFR_ASSERT(a_commit_only_on_end, i_clk, i_rst_n, (r_commit_ptr != $past(r_commit_ptr)) |-> $past(w_commit_move))
    `PWFR_ASSERT(a_read_only_on_hit, i_clk, i_rst_n, (r_rd_ptr != $past(r_rd_ptr)) |-> $past(w_rd_hit))
    `PWFR_ASSERT_IMP(a_read_has_no_event, i_clk, i_rst_n, r_out_valid && r_out_hit, r_out_event == EV_NONE)
    `PWFR_ASSERT_IMP(a_store_while_listening, i_clk, i_rst_n, w_store_en, r_listening && (ring_next(r_wr_ptr) != r_rd_ptr))

endmodule

// File: rtl/pulse_width_frame_receiver.sv
// ----------------------------------------------------------------------------
// pulse_width_frame_receiver
// pulse width decoder with byte framing, xor checksum and receive ring buffer
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one item per transaction: tuser selects a measured
//   interval (0) or a read of one received byte (1); tdata holds the interval
//   in timer ticks and its level. every item gives exactly one transaction on
//   the master stream: popped byte, byte-found flag in tuser, frame event code.
//   the config channel writes the eight code registers (index 0..7, others
//   are ignored); write it only while no item is in flight.
// throughput: one item per clock while tready on the master side stays high.
//   the front classifies an item in the cycle it is accepted (one reciprocal
//   multiply plus code compares) and pushes it into a four-entry command
//   queue; the back executes one command per cycle unless the master stalls.
// path: an item passes the command queue and then the back's result
//   register, which drives tvalid on the master stream.
// stall: while the master side holds tready low the result register holds,
//   the queue fills, and tready on the slave side drops once it is full.
// reset: synchronous, active low; clears code registers, frame state and all
//   ring pointers. the byte store itself is not cleared; only bytes written
//   by a committed frame are ever read back.
// ----------------------------------------------------------------------------
module pulse_width_frame_receiver import pwfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [UNITS_W-1:0]   i_cfg_data,
    // slave stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [23:0]          i_s_tdata,  // [15:0] interval_ticks, [16] interval_was_high
    input  logic                 i_s_tuser,  // [0] operation
    // master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,  // [7:0] read_data, [10:8] event_res
    output logic                 o_m_tuser   // [0] read_valid
);

    logic              w_push;
    t_cmd              w_front_cmd;
    logic              w_q_ready;
    logic              w_q_valid;
    t_cmd              w_q_cmd;
    logic              w_pop;
    logic [BYTE_W-1:0] w_read_data;
    logic              w_read_valid;
    t_event            w_event;

    // front: interval to units, high/low pairing, code match
    pwfr_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_cfg_ready         (o_cfg_ready),
        .i_valid             (i_s_tvalid),
        .i_operation         (i_s_tuser),
        .i_interval_ticks    (i_s_tdata[15:0]),
        .i_interval_was_high (i_s_tdata[16]),
        .i_queue_ready       (w_q_ready),
        .o_push              (w_push),
        .o_cmd               (w_front_cmd)
    );

    // decouples classification from execution
    pwfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    // back: frame state machine, ring buffer, result register
    pwfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_cmd_pop    (w_pop),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_read_data  (w_read_data),
        .o_read_valid (w_read_valid),
        .o_event      (w_event)
    );

    assign o_s_tready = w_q_ready;
    assign o_m_tdata  = {5'd0, w_event, w_read_data};
    assign o_m_tuser  = w_read_valid;

endmodule
